// ===== rtl/grid_maze_dfs_engine_core_assert.svh =====
// Assertion macros used by the back end of the maze search engine.
`ifndef GRID_MAZE_DFS_ENGINE_CORE_ASSERT_SVH
`define GRID_MAZE_DFS_ENGINE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GMD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GMD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/gmd_pkg.sv =====
// Types, codes and direction tables of the maze search engine.
package gmd_pkg;

    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    localparam logic [1:0] MARK_WALL = 2'd0;
    localparam logic [1:0] MARK_OPEN = 2'd1;
    localparam logic [1:0] MARK_DEAD = 2'd2;
    localparam logic [1:0] MARK_PATH = 2'd3;

    localparam logic [1:0] STAT_DONE   = 2'd0;
    localparam logic [1:0] STAT_FOUND  = 2'd1;
    localparam logic [1:0] STAT_NOPATH = 2'd2;

    localparam logic [3:0] NUM_DIRS = 4'd8;

    typedef struct packed {
        logic [1:0] op;
        logic [3:0] row;
        logic [3:0] col;
        logic       open;
        logic       in_grid;
    } cmd_t;

    typedef struct packed {
        logic [1:0] status;
        logic [1:0] mark;
        logic [7:0] path_cells;
    } result_t;

    // Row step of each direction, east first and then clockwise, as 5-bit two's complement.
    function automatic logic [4:0] dir_step_row(input logic [2:0] dir);
        logic [4:0] s;
        unique case (dir)
            3'd0, 3'd4:       s = 5'd0;
            3'd1, 3'd2, 3'd3: s = 5'd1;
            default:          s = 5'h1F;
        endcase
        return s;
    endfunction

    function automatic logic [4:0] dir_step_col(input logic [2:0] dir);
        logic [4:0] s;
        unique case (dir)
            3'd2, 3'd6:       s = 5'd0;
            3'd0, 3'd1, 3'd7: s = 5'd1;
            default:          s = 5'h1F;
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/gmd_front.sv =====
// Front end: accepts items, checks the cell range and queues commands.
module gmd_front #(
    parameter int ROWS = 12,
    parameter int COLS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  logic [1:0]     op,
    input  logic [3:0]     cell_row,
    input  logic [3:0]     cell_col,
    input  logic           cell_open,
    output logic           cmd_valid,
    output gmd_pkg::cmd_t  cmd,
    input  logic           cmd_pop
);

    gmd_pkg::cmd_t q_mem [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;
    gmd_pkg::cmd_t in_cmd;

    always_comb
    begin
        in_cmd.op      = op;
        in_cmd.row     = cell_row;
        in_cmd.col     = cell_col;
        in_cmd.open    = cell_open;
        in_cmd.in_grid = ({1'b0, cell_row} < 5'(ROWS)) && ({1'b0, cell_col} < 5'(COLS));
    end

    assign full      = (count_reg == 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_mem[rptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_pop && cmd_valid;

    always_comb
    begin
        wptr_next  = wptr_reg ^ do_push;
        rptr_next  = rptr_reg ^ do_pop;
        count_next = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem[wptr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/gmd_back.sv =====
// Back end: grid memory, path stack and the depth-first search sequencer.
`include "grid_maze_dfs_engine_core_assert.svh"

module gmd_back #(
    parameter int ROWS        = 12,
    parameter int COLS        = 16,
    parameter int STACK_DEPTH = 192
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    input  gmd_pkg::cmd_t    cmd,
    output logic             cmd_pop,
    input  logic [3:0]       start_row,
    input  logic [3:0]       start_col,
    input  logic [3:0]       goal_row,
    input  logic [3:0]       goal_col,
    output logic             res_push,
    output gmd_pkg::result_t res,
    input  logic             res_full
);

    localparam int NCELL = ROWS * COLS;
    localparam int AW    = $clog2(NCELL);
    localparam int SA    = $clog2(STACK_DEPTH);
    localparam int SW    = $clog2(STACK_DEPTH + 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_RDWAIT = 3'd1;
    localparam logic [2:0] ST_PROBE  = 3'd2;
    localparam logic [2:0] ST_CHECK  = 3'd3;
    localparam logic [2:0] ST_POP    = 3'd4;
    localparam logic [2:0] ST_GOAL   = 3'd5;
    localparam logic [2:0] ST_RESULT = 3'd6;

    function automatic logic [AW-1:0] cell_addr(input logic [3:0] r, input logic [3:0] c);
        logic [8:0] a;
        a = {5'd0, r} * 9'(COLS) + {5'd0, c};
        return a[AW-1:0];
    endfunction

    logic [1:0]    grid_mem [NCELL];
    logic [NCELL-1:0] cell_vld_reg;
    logic [11:0]   stack_mem [STACK_DEPTH];

    logic [2:0]    state_reg, state_next;
    logic [3:0]    cur_row_reg, cur_row_next;
    logic [3:0]    cur_col_reg, cur_col_next;
    logic [3:0]    dir_reg, dir_next;
    logic [SW-1:0] depth_reg, depth_next;
    logic [3:0]    nb_row_reg, nb_row_next;
    logic [3:0]    nb_col_reg, nb_col_next;
    gmd_pkg::result_t res_reg, res_next;

    logic          gw_en;
    logic [AW-1:0] gw_addr;
    logic [1:0]    gw_data;
    logic          gr_en;
    logic [AW-1:0] gr_addr;
    logic [1:0]    gr_data_reg;
    logic          gr_vld_reg;
    logic          sw_en;
    logic [SA-1:0] sw_addr;
    logic [11:0]   sw_data;
    logic          sr_en;
    logic [SA-1:0] sr_addr;
    logic [11:0]   sr_data_reg;

    logic [4:0]    nb_row, nb_col;
    logic          nb_inside;
    logic [1:0]    rd_mark;
    logic [SW-1:0] depth_inc;

    assign nb_row    = {1'b0, cur_row_reg} + gmd_pkg::dir_step_row(dir_reg[2:0]);
    assign nb_col    = {1'b0, cur_col_reg} + gmd_pkg::dir_step_col(dir_reg[2:0]);
    assign nb_inside = (nb_row < 5'(ROWS)) && (nb_col < 5'(COLS));
    assign rd_mark   = gr_vld_reg ? gr_data_reg : gmd_pkg::MARK_WALL;
    assign depth_inc = depth_reg + SW'(1);
    assign res       = res_reg;
    assign res_push  = (state_reg == ST_RESULT) && !res_full;

    always_comb
    begin
        state_next   = state_reg;
        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        dir_next     = dir_reg;
        depth_next   = depth_reg;
        nb_row_next  = nb_row_reg;
        nb_col_next  = nb_col_reg;
        res_next     = res_reg;
        cmd_pop      = 1'b0;
        gw_en        = 1'b0;
        gw_addr      = cell_addr(cur_row_reg, cur_col_reg);
        gw_data      = gmd_pkg::MARK_WALL;
        gr_en        = 1'b0;
        gr_addr      = cell_addr(nb_row[3:0], nb_col[3:0]);
        sw_en        = 1'b0;
        sw_addr      = depth_reg[SA-1:0];
        sw_data      = {cur_row_reg, cur_col_reg, dir_reg + 4'd1};
        sr_en        = 1'b0;
        sr_addr      = SA'(depth_reg - SW'(1));

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop  = 1'b1;
                    res_next = '0;
                    state_next = ST_RESULT;
                    if (cmd.op == gmd_pkg::OP_WRITE)
                    begin
                        gw_en   = cmd.in_grid;
                        gw_addr = cell_addr(cmd.row, cmd.col);
                        gw_data = cmd.open ? gmd_pkg::MARK_OPEN : gmd_pkg::MARK_WALL;
                    end
                    else if (cmd.op == gmd_pkg::OP_READ)
                    begin
                        if (cmd.in_grid)
                        begin
                            gr_en      = 1'b1;
                            gr_addr    = cell_addr(cmd.row, cmd.col);
                            state_next = ST_RDWAIT;
                        end
                    end
                    else if (cmd.op == gmd_pkg::OP_SEARCH)
                    begin
                        depth_next = '0;
                        dir_next   = '0;
                        if (({1'b0, start_row} < 5'(ROWS)) && ({1'b0, start_col} < 5'(COLS)))
                        begin
                            cur_row_next = start_row;
                            cur_col_next = start_col;
                            state_next   = ST_PROBE;
                        end
                        else
                        begin
                            res_next.status = gmd_pkg::STAT_NOPATH;
                        end
                    end
                end
            end
            ST_RDWAIT:
            begin
                res_next.mark = rd_mark;
                state_next    = ST_RESULT;
            end
            ST_PROBE:
            begin
                if (dir_reg >= gmd_pkg::NUM_DIRS)
                begin
                    // Every direction tried: dead end; back up, or no path at depth 0.
                    gw_en   = 1'b1;
                    gw_data = gmd_pkg::MARK_DEAD;
                    if (depth_reg == '0)
                    begin
                        res_next.status = gmd_pkg::STAT_NOPATH;
                        state_next      = ST_RESULT;
                    end
                    else
                    begin
                        sr_en      = 1'b1;
                        depth_next = depth_reg - SW'(1);
                        state_next = ST_POP;
                    end
                end
                else if (nb_inside)
                begin
                    gr_en       = 1'b1;
                    nb_row_next = nb_row[3:0];
                    nb_col_next = nb_col[3:0];
                    state_next  = ST_CHECK;
                end
                else
                begin
                    dir_next = dir_reg + 4'd1;
                end
            end
            ST_CHECK:
            begin
                if (rd_mark == gmd_pkg::MARK_OPEN)
                begin
                    gw_en   = 1'b1;
                    gw_data = gmd_pkg::MARK_PATH;
                    if (depth_reg >= SW'(STACK_DEPTH))
                    begin
                        res_next.status = gmd_pkg::STAT_NOPATH;
                        state_next      = ST_RESULT;
                    end
                    else
                    begin
                        sw_en        = 1'b1;
                        depth_next   = depth_inc;
                        cur_row_next = nb_row_reg;
                        cur_col_next = nb_col_reg;
                        dir_next     = '0;
                        if ((nb_row_reg == goal_row) && (nb_col_reg == goal_col))
                        begin
                            res_next.status     = gmd_pkg::STAT_FOUND;
                            res_next.path_cells = 8'(depth_inc);
                            state_next          = ST_GOAL;
                        end
                        else
                        begin
                            state_next = ST_PROBE;
                        end
                    end
                end
                else
                begin
                    dir_next   = dir_reg + 4'd1;
                    state_next = ST_PROBE;
                end
            end
            ST_POP:
            begin
                cur_row_next = sr_data_reg[11:8];
                cur_col_next = sr_data_reg[7:4];
                dir_next     = sr_data_reg[3:0];
                state_next   = ST_PROBE;
            end
            ST_GOAL:
            begin
                gw_en      = 1'b1;
                gw_data    = gmd_pkg::MARK_PATH;
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!res_full)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (gw_en)
        begin
            grid_mem[gw_addr] <= gw_data;
        end
        if (gr_en)
        begin
            gr_data_reg <= grid_mem[gr_addr];
            gr_vld_reg  <= cell_vld_reg[gr_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sw_en)
        begin
            stack_mem[sw_addr] <= sw_data;
        end
        if (sr_en)
        begin
            sr_data_reg <= stack_mem[sr_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_vld_reg <= '0;
        end
        else if (gw_en)
        begin
            cell_vld_reg[gw_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        nb_row_reg <= nb_row_next;
        nb_col_reg <= nb_col_next;
        res_reg    <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cur_row_reg <= '0;
            cur_col_reg <= '0;
            dir_reg     <= '0;
            depth_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cur_row_reg <= cur_row_next;
            cur_col_reg <= cur_col_next;
            dir_reg     <= dir_next;
            depth_reg   <= depth_next;
        end
    end

    `GMD_ASSERT_NOW(a_depth_bound, 1'b1, depth_reg <= SW'(STACK_DEPTH), "stack depth overflow")
    `GMD_ASSERT_NOW(a_push_ok, sw_en, depth_reg < SW'(STACK_DEPTH), "push into a full stack")
    `GMD_ASSERT_NEXT(a_pop_next, sr_en, state_reg == ST_POP, "pop data not consumed")
    `GMD_ASSERT_NOW(a_dir_bound, state_reg == ST_CHECK, dir_reg < gmd_pkg::NUM_DIRS,
        "probe direction out of range")

endmodule

// ===== rtl/gmd_outq.sv =====
// Result queue: holds finished results until the consumer pops them.
module gmd_outq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             res_push,
    input  gmd_pkg::result_t res,
    output logic             res_full,
    output logic             empty,
    input  logic             pop,
    output logic [1:0]       status,
    output logic [1:0]       cell_mark,
    output logic [7:0]       path_cells
);

    gmd_pkg::result_t q_mem [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_pop;

    assign res_full   = (count_reg == 2'd2);
    assign empty      = (count_reg == 2'd0);
    assign do_pop     = pop && !empty;
    assign status     = q_mem[rptr_reg].status;
    assign cell_mark  = q_mem[rptr_reg].mark;
    assign path_cells = q_mem[rptr_reg].path_cells;

    always_comb
    begin
        wptr_next  = wptr_reg ^ res_push;
        rptr_next  = rptr_reg ^ do_pop;
        count_next = count_reg + {1'b0, res_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            q_mem[wptr_reg] <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/grid_maze_dfs_engine_core.sv =====
// Top level of the maze search engine: config registers, front end, engine, result queue.
// A write or unused op goes straight to the result state; an in-grid read awaits its grid read.
// A search reads and checks each in-bounds neighbor, skips off-grid directions
// and marks each dead end, then backs up one level or, at the start, reports no path.
// One item is worked at a time by the engine sequencer; a 2-entry queue on each side.
// Reset is asynchronous: all cells read as wall at once, no clearing pass is needed.
module grid_maze_dfs_engine_core #(
    parameter int ROWS        = 12,
    parameter int COLS        = 16,
    parameter int STACK_DEPTH = 192
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] op,
    input  logic [3:0] cell_row,
    input  logic [3:0] cell_col,
    input  logic       cell_open,
    output logic       empty,
    input  logic       pop,
    output logic [1:0] status,
    output logic [1:0] cell_mark,
    output logic [7:0] path_cells,
    input  logic       cfg_we,
    input  logic [1:0] cfg_addr,
    input  logic [3:0] cfg_wdata
);

    localparam logic [1:0] REG_START_ROW = 2'd0;
    localparam logic [1:0] REG_START_COL = 2'd1;
    localparam logic [1:0] REG_GOAL_ROW  = 2'd2;
    localparam logic [1:0] REG_GOAL_COL  = 2'd3;

    logic [3:0] start_row_reg, start_col_reg, goal_row_reg, goal_col_reg;
    logic             cmd_valid, cmd_pop, res_push, res_full;
    gmd_pkg::cmd_t    cmd;
    gmd_pkg::result_t res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_row_reg <= 4'd0;
            start_col_reg <= 4'd0;
            goal_row_reg  <= 4'd11;
            goal_col_reg  <= 4'd15;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_START_ROW: start_row_reg <= cfg_wdata;
                REG_START_COL: start_col_reg <= cfg_wdata;
                REG_GOAL_ROW:  goal_row_reg  <= cfg_wdata;
                REG_GOAL_COL:  goal_col_reg  <= cfg_wdata;
                default:       start_row_reg <= start_row_reg;
            endcase
        end
    end

    gmd_front #(.ROWS(ROWS), .COLS(COLS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .op        (op),
        .cell_row  (cell_row),
        .cell_col  (cell_col),
        .cell_open (cell_open),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    gmd_back #(.ROWS(ROWS), .COLS(COLS), .STACK_DEPTH(STACK_DEPTH)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .start_row (start_row_reg),
        .start_col (start_col_reg),
        .goal_row  (goal_row_reg),
        .goal_col  (goal_col_reg),
        .res_push  (res_push),
        .res       (res),
        .res_full  (res_full)
    );

    gmd_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .res_push   (res_push),
        .res        (res),
        .res_full   (res_full),
        .empty      (empty),
        .pop        (pop),
        .status     (status),
        .cell_mark  (cell_mark),
        .path_cells (path_cells)
    );

endmodule
